FILE: rtl/tvdfl_pkg.sv
`timescale 1ns / 1ps
package tvdfl_pkg;

	// Field and datapath widths
	localparam int IN_W      = 32;          // signed input differences
	localparam int OUT_W     = IN_W + 1;    // signed limited slope
	localparam int MAG_W     = IN_W;        // unsigned magnitudes and quotient
	localparam int DEN_W     = MAG_W + 1;   // |c| + |u| + 1
	localparam int NUM_W     = 2 * MAG_W;   // 2 |c| |u|
	localparam int DIV_STEPS = MAG_W;       // one quotient bit per divider cell

	// Limiter selection
	typedef enum logic [1:0] {
		MODE_NONE     = 2'd0,
		MODE_SUPERBEE = 2'd1,
		MODE_VANLEER  = 2'd2,
		MODE_MINMOD   = 2'd3
	} mode_t;

	// Side information that travels with a request down the divider chain
	typedef struct packed {
		logic             vl;       // result is the quotient
		logic             neg;      // upwind input negative
		logic [MAG_W-1:0] alt_mag;  // superbee / minmod / zero magnitude
	} tvdfl_ctl_t;

	// Restoring divider state: partial remainder, numerator bits that are
	// still to come (shifted out at the top while quotient bits shift in)
	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [MAG_W-1:0] nq;
		logic [DEN_W-1:0] den;
	} tvdfl_div_t;

endpackage

FILE: rtl/tvd_flux_limiter_top.sv
`timescale 1ns / 1ps
// TVD slope limiter (none / superbee / van Leer / minmod).
//
// Request channel: item_valid, item_stall, upwind_diff, central_diff (signed,
// 32 bits). A request is taken at a rising edge with item_valid high and
// item_stall low. Result channel: result_valid, result_stall, limited_value
// (signed, 33 bits); a result is taken with result_valid high and result_stall
// low. limiter_mode is written by limiter_mode_we; change it only while the
// block is empty.
//
// The path from request to result_valid runs through two front stages
// (magnitudes, then the 32x32 product and divisor), a chain of 32 divider
// cells that each produce one quotient bit, and the output register. Every
// stage advances independently, so one request is taken each cycle while
// item_stall is low; the divider cells are pipelined, one division per cell.
//
// A stalled result holds in the output register while bubbles upstream
// still close up; item_stall rises only when every stage is full and the
// result is stalled. Reset clears all valid flags and sets the mode to none.
module tvd_flux_limiter_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 limiter_mode_we,
	input  logic [1:0]                           limiter_mode,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic signed [tvdfl_pkg::IN_W-1:0]    upwind_diff,
	input  logic signed [tvdfl_pkg::IN_W-1:0]    central_diff,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [tvdfl_pkg::OUT_W-1:0]   limited_value
);
	import tvdfl_pkg::*;

	mode_t            mode_q;
	logic             v    [0:DIV_STEPS];
	logic             stl  [0:DIV_STEPS];
	tvdfl_ctl_t       ctl  [0:DIV_STEPS];
	tvdfl_div_t       dv   [0:DIV_STEPS];
	logic             out_valid_q;
	logic [OUT_W-1:0] value_q;
	logic             out_stl;
	logic [MAG_W-1:0] fin_mag;
	logic [OUT_W-1:0] fin_val;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NONE;
		end else if (limiter_mode_we) begin
			mode_q <= mode_t'(limiter_mode);
		end
	end

	tvdfl_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode         (mode_q),
		.in_valid     (item_valid),
		.in_stall     (item_stall),
		.upwind_diff  (upwind_diff),
		.central_diff (central_diff),
		.out_valid    (v[0]),
		.out_stall    (stl[0]),
		.out_ctl      (ctl[0]),
		.out_div      (dv[0])
	);

	// Divider cell chain
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
		tvdfl_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v[i]),
			.in_stall  (stl[i]),
			.in_ctl    (ctl[i]),
			.in_div    (dv[i]),
			.out_valid (v[i+1]),
			.out_stall (stl[i+1]),
			.out_ctl   (ctl[i+1]),
			.out_div   (dv[i+1])
		);
	end

	// Select magnitude and apply the common sign
	always_comb begin
		fin_mag = ctl[DIV_STEPS].vl ? dv[DIV_STEPS].nq : ctl[DIV_STEPS].alt_mag;
		fin_val = ctl[DIV_STEPS].neg ? (OUT_W'(0) - {1'b0, fin_mag}) : {1'b0, fin_mag};
	end

	// Output register
	assign out_stl          = out_valid_q && result_stall;
	assign stl[DIV_STEPS]   = out_stl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_stl) begin
			out_valid_q <= v[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (!out_stl && v[DIV_STEPS]) begin
			value_q <= fin_val;
		end
	end

	assign result_valid  = out_valid_q;
	assign limited_value = value_q;

	// Assertions
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("request stalled while output can drain");

	a_no_min_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(limited_value[OUT_W-1] && (limited_value[OUT_W-2:0] == '0)))
		else $error("limited value out of range");

	a_zero_quot: assert property (@(posedge clk) disable iff (!arst_n)
		(v[DIV_STEPS] && !ctl[DIV_STEPS].vl) |-> (dv[DIV_STEPS].nq == '0))
		else $error("non van Leer request produced a quotient");

endmodule

FILE: rtl/tvdfl_front.sv
`timescale 1ns / 1ps
module tvdfl_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tvdfl_pkg::mode_t                     mode,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [tvdfl_pkg::IN_W-1:0]    upwind_diff,
	input  logic signed [tvdfl_pkg::IN_W-1:0]    central_diff,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output tvdfl_pkg::tvdfl_ctl_t                out_ctl,
	output tvdfl_pkg::tvdfl_div_t                out_div
);
	import tvdfl_pkg::*;

	logic             v_s1, v_s2;
	logic             stall_s1, stall_s2;
	logic [MAG_W-1:0] mu_s1, mc_s1;
	logic             match_s1, neg_s1;
	mode_t            mode_s1;
	logic [NUM_W-1:0] prod_s2;
	logic [DEN_W-1:0] den_s2;
	tvdfl_ctl_t       ctl_s2;

	logic [MAG_W-1:0] mu_abs, mc_abs;
	logic             match_in;
	logic [DEN_W-1:0] mu2, mc2, sb_a, sb_b, sb_max;
	logic [MAG_W-1:0] alt_mag;
	logic [NUM_W-1:0] num;

	// Stall chain: a stage holds only when full and its successor holds
	assign stall_s2 = v_s2 && out_stall;
	assign stall_s1 = v_s1 && stall_s2;
	assign in_stall = stall_s1;

	// Magnitudes and sign agreement of the inputs
	always_comb begin
		mu_abs   = upwind_diff[IN_W-1]  ? MAG_W'(~upwind_diff + 1'b1)  : MAG_W'(upwind_diff);
		mc_abs   = central_diff[IN_W-1] ? MAG_W'(~central_diff + 1'b1) : MAG_W'(central_diff);
		match_in = (upwind_diff != '0) && (central_diff != '0)
			&& (upwind_diff[IN_W-1] == central_diff[IN_W-1]);
	end

	// Stage 1: register magnitudes, sign and mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!stall_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s1 && in_valid) begin
			mu_s1    <= mu_abs;
			mc_s1    <= mc_abs;
			match_s1 <= match_in;
			neg_s1   <= upwind_diff[IN_W-1];
			mode_s1  <= mode;
		end
	end

	// Superbee and minmod magnitudes
	always_comb begin
		mu2     = {mu_s1, 1'b0};
		mc2     = {mc_s1, 1'b0};
		sb_a    = ({1'b0, mc_s1} < mu2) ? {1'b0, mc_s1} : mu2;
		sb_b    = (mc2 < {1'b0, mu_s1}) ? mc2 : {1'b0, mu_s1};
		sb_max  = (sb_a > sb_b) ? sb_a : sb_b;
		alt_mag = '0;
		if (match_s1) begin
			case (mode_s1)
				MODE_SUPERBEE: alt_mag = MAG_W'(sb_max);
				MODE_MINMOD:   alt_mag = (mc_s1 < mu_s1) ? mc_s1 : mu_s1;
				default:       alt_mag = '0;
			endcase
		end
	end

	// Stage 2: product and divisor for van Leer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!stall_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s2 && v_s1) begin
			prod_s2         <= NUM_W'(mu_s1) * NUM_W'(mc_s1);
			den_s2          <= DEN_W'(mu_s1) + DEN_W'(mc_s1) + DEN_W'(1);
			ctl_s2.vl       <= match_s1 && (mode_s1 == MODE_VANLEER);
			ctl_s2.neg      <= neg_s1;
			ctl_s2.alt_mag  <= alt_mag;
		end
	end

	// Divider entry: numerator 2|c||u|, zero when the quotient is not used
	always_comb begin
		num          = ctl_s2.vl ? {prod_s2[NUM_W-2:0], 1'b0} : '0;
		out_div.rem  = {1'b0, num[NUM_W-1:MAG_W]};
		out_div.nq   = num[MAG_W-1:0];
		out_div.den  = den_s2;
		out_ctl      = ctl_s2;
		out_valid    = v_s2;
	end

endmodule

FILE: rtl/tvdfl_div_cell.sv
`timescale 1ns / 1ps
module tvdfl_div_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  tvdfl_pkg::tvdfl_ctl_t  in_ctl,
	input  tvdfl_pkg::tvdfl_div_t  in_div,
	output logic                   out_valid,
	input  logic                   out_stall,
	output tvdfl_pkg::tvdfl_ctl_t  out_ctl,
	output tvdfl_pkg::tvdfl_div_t  out_div
);
	import tvdfl_pkg::*;

	logic         v_q;
	tvdfl_ctl_t   ctl_q;
	tvdfl_div_t   div_q;
	tvdfl_div_t   div_nxt;
	logic [DEN_W:0] trial, diff;
	logic         ge;

	assign in_stall = v_q && out_stall;

	// One restoring step: bring down a numerator bit, try the subtract
	always_comb begin
		trial       = {in_div.rem, in_div.nq[MAG_W-1]};
		diff        = trial - {1'b0, in_div.den};
		ge          = !diff[DEN_W];
		div_nxt.rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		div_nxt.nq  = {in_div.nq[MAG_W-2:0], ge};
		div_nxt.den = in_div.den;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (!in_stall) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			ctl_q <= in_ctl;
			div_q <= div_nxt;
		end
	end

	assign out_valid = v_q;
	assign out_ctl   = ctl_q;
	assign out_div   = div_q;

endmodule
